// File: rtl/core/mh2_pkg.sv
// ---------------------------------------------------------------------------
// mh2_pkg
// Shared types and constants for the streaming MurmurHash2 core.
// ---------------------------------------------------------------------------
`default_nettype none

package mh2_pkg;

   localparam logic [31:0] MUR_M        = 32'h5bd1e995;
   localparam int          MIX_SHIFT    = 24;
   localparam int          FIN_SHIFT_A  = 13;
   localparam int          FIN_SHIFT_B  = 15;

   localparam int          QUEUE_DEPTH  = 2;
   localparam int          QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_FULL = 2'd0,
      OP_TAIL = 2'd1,
      OP_NONE = 2'd2
   } word_op_type;

   typedef struct packed {
      logic [31:0] word;
      word_op_type op;
      logic        first;
      logic        last;
      logic [31:0] init;
   } queue_entry_type;

   function automatic logic [31:0] mul_m(input logic [31:0] a);
      begin
         mul_m = a * MUR_M;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/mh2_front.sv
// ---------------------------------------------------------------------------
// mh2_front
// Accepts key words, classifies each as full word, tail or empty, masks
// tail bytes, forms seed XOR key length as the initial hash, then pushes to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_front (
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [31:0]              req_key_word,
   input  wire logic [2:0]               req_bytes_in_word,
   input  wire logic [31:0]              req_key_length,
   input  wire logic [31:0]              req_seed,
   input  wire logic                     req_first,
   input  wire logic                     req_last,
   input  wire logic                     queue_full,
   output logic                          queue_push,
   output mh2_pkg::queue_entry_type      queue_entry
);
   import mh2_pkg::*;

   logic [31:0] tail_mask;

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   always_comb begin
      tail_mask = 32'h0000_0000;
      queue_entry.op = OP_FULL;
      if (req_last) begin
         unique case (req_bytes_in_word)
            3'd0: begin
               queue_entry.op = OP_NONE;
            end
            3'd1: begin
               queue_entry.op = OP_TAIL;
               tail_mask      = 32'h0000_00ff;
            end
            3'd2: begin
               queue_entry.op = OP_TAIL;
               tail_mask      = 32'h0000_ffff;
            end
            3'd3: begin
               queue_entry.op = OP_TAIL;
               tail_mask      = 32'h00ff_ffff;
            end
            default: begin
               queue_entry.op = OP_FULL;
            end
         endcase
      end
      queue_entry.word  = (queue_entry.op == OP_TAIL) ? (req_key_word & tail_mask)
                                                      : req_key_word;
      queue_entry.first = req_first;
      queue_entry.last  = req_last;
      queue_entry.init  = req_seed ^ req_key_length;
   end

endmodule

`default_nettype wire

// File: rtl/core/mh2_queue.sv
// ---------------------------------------------------------------------------
// mh2_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire mh2_pkg::queue_entry_type push_entry,
   input  wire logic                     pop,
   output logic                          full,
   output logic                          empty,
   output mh2_pkg::queue_entry_type      head
);
   import mh2_pkg::*;

   queue_entry_type       mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      begin
         next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
      end
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/mh2_back.sv
// ---------------------------------------------------------------------------
// mh2_back
// Sequencer around one constant multiplier: word mixing, fold, tail,
// finalisation, and the registered result word.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     queue_empty,
   input  wire mh2_pkg::queue_entry_type queue_head,
   output logic                          queue_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [31:0]                   rsp_hash
);
   import mh2_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_K1   = 6'b000010,
      ST_K2   = 6'b000100,
      ST_HM   = 6'b001000,
      ST_TAIL = 6'b010000,
      ST_FIN  = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [31:0]    h_ff, h_in;
   logic [31:0]    k_ff, k_in;
   logic [31:0]    w_ff, w_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_hash_ff, rsp_hash_in;
   logic [31:0]    mul_a;
   logic [31:0]    mul_p;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign queue_pop = (state_ff == ST_IDLE) && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;
   assign mul_p     = mul_m(mul_a);

   always_comb begin
      unique case (state_ff)
         ST_K1:   mul_a = w_ff;
         ST_K2:   mul_a = k_ff ^ (k_ff >> MIX_SHIFT);
         ST_HM:   mul_a = h_ff;
         ST_TAIL: mul_a = h_ff ^ w_ff;
         ST_FIN:  mul_a = h_ff ^ (h_ff >> FIN_SHIFT_A);
         default: mul_a = w_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      last_in      = last_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               w_in    = queue_head.word;
               last_in = queue_head.last;
               if (queue_head.first) begin
                  h_in = queue_head.init;
               end
               unique case (queue_head.op)
                  OP_FULL: state_in = ST_K1;
                  OP_TAIL: state_in = ST_TAIL;
                  OP_NONE: state_in = ST_FIN;
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_K1: begin
            k_in     = mul_p;
            state_in = ST_K2;
         end
         ST_K2: begin
            k_in     = mul_p;
            state_in = ST_HM;
         end
         ST_HM: begin
            h_in     = mul_p ^ k_ff;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_TAIL: begin
            h_in     = mul_p;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_hash_in  = mul_p ^ (mul_p >> FIN_SHIFT_B);
               rsp_valid_in = 1'b1;
               h_in         = 32'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      w_ff        <= w_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/murmur2_hash32.sv
// ---------------------------------------------------------------------------
// murmur2_hash32
// Streaming 32-bit MurmurHash2 over little-endian key words.
// ---------------------------------------------------------------------------
// channel   direction   handshake            payload
// req_      in          req_valid/req_ready  key_word, bytes_in_word,
//                                            key_length, seed, first, last
// rsp_      out         rsp_valid/rsp_ready  hash (last word only)
//
// In the back end a full word is dequeued, then makes three passes through
// the single 32x32 constant multiplier. A 1-3 byte tail makes one pass,
// an empty last word none, and a last word adds a finalisation pass.
// The front and a 2-entry queue take words while the back end is busy.
// Reset clears the running hash to zero and empties the queue.
// The result register frees the back end while a hash waits on rsp_ready.
// ---------------------------------------------------------------------------
`default_nettype none

module murmur2_hash32 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_key_word,
   input  wire logic [2:0]  req_bytes_in_word,
   input  wire logic [31:0] req_key_length,
   input  wire logic [31:0] req_seed,
   input  wire logic        req_first,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_hash
);
   import mh2_pkg::*;

   queue_entry_type push_entry;
   queue_entry_type head;
   logic            push;
   logic            pop;
   logic            full;
   logic            empty;

   mh2_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_key_word      (req_key_word),
      .req_bytes_in_word (req_bytes_in_word),
      .req_key_length    (req_key_length),
      .req_seed          (req_seed),
      .req_first         (req_first),
      .req_last          (req_last),
      .queue_full        (full),
      .queue_push        (push),
      .queue_entry       (push_entry)
   );

   mh2_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   mh2_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (empty),
      .queue_head  (head),
      .queue_pop   (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_hash    (rsp_hash)
   );

endmodule

`default_nettype wire
